// ----- src/thdq_pkg.sv -----
// Shared types and constants for the tap-hold deferred event queue.
package thdq_pkg;

  localparam int MAX_OUT = 16;                   // fired events per tick, at most
  localparam int NW      = $clog2(MAX_OUT + 1);  // width of the fired-event counter
  localparam int CFG_AW  = 3;                    // APB byte address width
  localparam int CFG_DW  = 32;

  localparam logic [1:0] CMD_ENQ    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] KIND_ENQ_ACK    = 2'd0;
  localparam logic [1:0] KIND_CANCEL_ACK = 2'd1;
  localparam logic [1:0] KIND_FIRED      = 2'd2;
  localparam logic [1:0] KIND_NONE_DUE   = 2'd3;

  localparam logic REG_TAP_TERM = 1'b0;          // register index, paddr[2]
  localparam logic [15:0] TAP_TERM_RESET = 16'd200;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] keycode;
    logic [7:0]  key_row;
    logic [7:0]  key_col;
    logic        pressed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [15:0] out_keycode;
    logic [7:0]  out_row;
    logic [7:0]  out_col;
    logic        out_pressed;
    logic        last;
  } out_item_t;

  // one queue slot as stored in the entry memory
  typedef struct packed {
    logic [31:0] fire_time;
    logic        cancelled;
    logic [15:0] keycode;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        pressed;
  } entry_t;

  typedef struct packed {
    logic match;   // entry position equals key position
    logic due;     // now - fire_time is zero or positive
  } cmp_res_t;

endpackage

// ----- src/thdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module thdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/thdq_cmp.sv -----
// Shared compare unit: key position match and wrap-safe due test.
module thdq_cmp
  import thdq_pkg::*;
(
  input  logic [31:0] now_time,
  input  entry_t      entry,
  input  logic [7:0]  key_row,
  input  logic [7:0]  key_col,
  output cmp_res_t    res
);

  logic [31:0] diff;

  assign diff      = now_time - entry.fire_time;
  assign res.due   = ~diff[31];
  assign res.match = (entry.row == key_row) && (entry.col == key_col);

endmodule

// ----- src/tap_hold_deferred_event_queue_core.sv -----
// Top level: deferred key event queue with walk sequencer and APB register.
//
//  channel | handshake            | payload / signals
//  --------+----------------------+-------------------------------------------
//  in      | in_valid, in_stall   | in_data  (in_item_t: command, key, position)
//  out     | out_valid, out_stall | out_data (out_item_t: kind, ok, event, last)
//  cfg     | psel/penable/pwrite  | paddr, pwdata, prdata, pready (tap term)
//
// Enqueue writes the entry when accepted with room and answers from S_RESP. Cancel
// and tick walk the queue through the entry memory's single registered read
// port, with a read state and an evaluate state (S_CRD/S_CEV, S_TRD/S_TEV) per
// entry visited; a tick ends in S_TFIN and a cancel in S_RESP.
// in_stall is high from acceptance until the last result is loaded into the
// output register; out_stall holds the final result and, once a fired event is held, the tick walk.
// Reset is synchronous; the entry memory needs no clearing pass.
module tap_hold_deferred_event_queue_core
  import thdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW:0] DEPTH_S = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RESP = 3'd1;
  localparam logic [2:0] S_CRD  = 3'd2;
  localparam logic [2:0] S_CEV  = 3'd3;
  localparam logic [2:0] S_TRD  = 3'd4;
  localparam logic [2:0] S_TEV  = 3'd5;
  localparam logic [2:0] S_TFIN = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [15:0]   tap_r;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic          ok_r, ok_nxt;
  logic          pend_v_r, pend_v_nxt;
  entry_t        pend_r, pend_nxt;
  in_item_t      key_r, key_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  cmp_res_t      cmp;

  logic          accept, out_free, emit;
  out_item_t     emit_item;
  logic [CW:0]   slot_sum;
  logic [IW-1:0] slot_idx, head_inc;

  thdq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  thdq_cmp u_cmp (
    .now_time (now_r),
    .entry    (ram_rdata),
    .key_row  (key_r.key_row),
    .key_col  (key_r.key_col),
    .res      (cmp)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TAP_TERM) ? CFG_DW'(tap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= TAP_TERM_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TAP_TERM) begin
      tap_r <= pwdata[15:0];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // slot = (head + idx, or head + count while idle) mod depth; the sum stays below twice the depth
  assign slot_sum = {1'b0, CW'(head_r)} + {1'b0, (state_r == S_IDLE) ? cnt_r : idx_r};
  assign slot_idx = (slot_sum >= DEPTH_S) ? IW'(slot_sum - DEPTH_S) : IW'(slot_sum);
  assign head_inc = (head_r == IW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    now_nxt    = now_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    kind_nxt   = kind_r;
    ok_nxt     = ok_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    key_nxt    = key_r;
    slot_nxt   = slot_r;
    ram_we     = 1'b0;
    ram_waddr  = slot_idx;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = slot_idx;
    emit       = 1'b0;
    emit_item  = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = in_data;
          idx_nxt = '0;
          n_nxt   = '0;
          ok_nxt  = 1'b0;
          pend_v_nxt = 1'b0;
          case (in_data.command)
            CMD_ENQ: begin
              kind_nxt  = KIND_ENQ_ACK;
              state_nxt = S_RESP;
              if (cnt_r < DEPTH_C) begin
                ram_we              = 1'b1;
                ram_wdata.fire_time = now_r + 32'(tap_r);
                ram_wdata.cancelled = 1'b0;
                ram_wdata.keycode   = in_data.keycode;
                ram_wdata.row       = in_data.key_row;
                ram_wdata.col       = in_data.key_col;
                ram_wdata.pressed   = in_data.pressed;
                cnt_nxt             = cnt_r + 1'b1;
                ok_nxt              = 1'b1;
              end
            end
            CMD_CANCEL: begin
              kind_nxt  = KIND_CANCEL_ACK;
              state_nxt = (cnt_r == '0) ? S_RESP : S_CRD;
            end
            CMD_TICK: begin
              now_nxt   = now_r + 32'd1;
              state_nxt = S_TRD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RESP: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_item.kind = kind_r;
          emit_item.ok   = ok_r;
          emit_item.last = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_CRD: begin
        ram_re    = 1'b1;
        slot_nxt  = slot_idx;
        state_nxt = S_CEV;
      end

      S_CEV: begin
        // oldest match wins, even if already cancelled
        if (cmp.match) begin
          ram_we              = 1'b1;
          ram_waddr           = slot_r;
          ram_wdata.cancelled = 1'b1;
          ok_nxt              = 1'b1;
          state_nxt           = S_RESP;
        end else if (idx_r + 1'b1 == cnt_r) begin
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_CRD;
        end
      end

      S_TRD: begin
        ram_raddr = head_r;
        if (cnt_r == '0 || n_r == NW'(MAX_OUT)) begin
          state_nxt = S_TFIN;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_TEV;
        end
      end

      S_TEV: begin
        if (ram_rdata.cancelled) begin
          head_nxt  = head_inc;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_TRD;
        end else if (!cmp.due) begin
          state_nxt = S_TFIN;
        end else if (!pend_v_r || out_free) begin
          // the held event is not the last one: send it on
          if (pend_v_r) begin
            emit                  = 1'b1;
            emit_item.kind        = KIND_FIRED;
            emit_item.out_keycode = pend_r.keycode;
            emit_item.out_row     = pend_r.row;
            emit_item.out_col     = pend_r.col;
            emit_item.out_pressed = pend_r.pressed;
          end
          pend_nxt   = ram_rdata;
          pend_v_nxt = 1'b1;
          n_nxt      = n_r + 1'b1;
          head_nxt   = head_inc;
          cnt_nxt    = cnt_r - 1'b1;
          state_nxt  = S_TRD;
        end
      end

      S_TFIN: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_item.last = 1'b1;
          if (pend_v_r) begin
            emit_item.kind        = KIND_FIRED;
            emit_item.out_keycode = pend_r.keycode;
            emit_item.out_row     = pend_r.row;
            emit_item.out_col     = pend_r.col;
            emit_item.out_pressed = pend_r.pressed;
          end else begin
            emit_item.kind = KIND_NONE_DUE;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_data_nxt  = emit_item;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    kind_r     <= kind_nxt;
    ok_r       <= ok_nxt;
    pend_r     <= pend_nxt;
    key_r      <= key_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above queue depth");

  a_fired_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEV || state_r == S_TFIN) |-> n_r <= NW'(MAX_OUT))
    else $error("too many fired events held for one tick");

  a_fired_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == KIND_FIRED) |-> !out_data_r.ok)
    else $error("fired event carries ok");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind != KIND_FIRED) |-> out_data_r.last)
    else $error("ack or nothing-due result without last");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("held fired event left behind after a tick");

endmodule

// ----- dv/tap_hold_deferred_event_queue_core_tb.sv -----
// Self-checking testbench for the tap-hold deferred event queue core.
`timescale 1ns / 100ps

module tap_hold_deferred_event_queue_core_tb
  import thdq_pkg::*;
();

  localparam int CLK_PERIOD     = 8;
  localparam int DEPTH          = 16;
  localparam int IDLE_PCT       = 37;
  localparam int STALL_STRETCH  = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 50;   // idle margin after the last result
  localparam logic [CFG_AW-1:0] TAP_TERM_ADDR = {REG_TAP_TERM, 2'b00};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // shadow of the event queue
  logic [15:0] tap_term = TAP_TERM_RESET;
  logic [31:0] now_ticks = '0;
  logic [31:0] ev_fire [DEPTH];
  logic        ev_dead [DEPTH];
  logic [15:0] ev_key [DEPTH];
  logic [7:0]  ev_row [DEPTH];
  logic [7:0]  ev_col [DEPTH];
  logic        ev_press [DEPTH];
  logic [3:0]  ev_head = '0;
  logic [4:0]  ev_count = '0;

  in_item_t  cmd_q [$];
  out_item_t awaited [$];

  logic [7:0] pool_row [6];
  logic [7:0] pool_col [6];

  int  n_errs = 0;
  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_fired = 0;
  int  n_dropped = 0;
  int  n_cancel_hit = 0;
  int  n_cancel_miss = 0;
  int  n_idle_ticks = 0;
  int  longest_burst = 0;
  int  n_tap_settings = 0;
  bit  steady = 1'b0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  tap_hold_deferred_event_queue_core #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic string show(input out_item_t r);
    return $sformatf("kind=%0d ok=%0d key=%h row=%h col=%h pressed=%0d last=%0d",
                     r.kind, r.ok, r.out_keycode, r.out_row, r.out_col,
                     r.out_pressed, r.last);
  endfunction

  function automatic in_item_t key_cmd(input logic [1:0] cmd, input logic [15:0] key,
                                       input logic [7:0] row, input logic [7:0] col,
                                       input logic pressed);
    in_item_t it;
    it.command = cmd;
    it.keycode = key;
    it.key_row = row;
    it.key_col = col;
    it.pressed = pressed;
    return it;
  endfunction

  // Applies one accepted command to the shadow queue and queues its results.
  task automatic step_event_queue(input in_item_t it);
    out_item_t   res;
    out_item_t   held;
    logic [3:0]  s;
    logic [31:0] lag;
    int          n;
    int          i;
    bit          done;
    res = '0;
    res.last = 1'b1;
    held = '0;
    n = 0;
    done = 1'b0;
    case (it.command)
      CMD_ENQ: begin
        res.kind = KIND_ENQ_ACK;
        if (ev_count < DEPTH) begin
          s = ev_head + ev_count[3:0];
          ev_fire[s]  = now_ticks + {16'd0, tap_term};
          ev_dead[s]  = 1'b0;
          ev_key[s]   = it.keycode;
          ev_row[s]   = it.key_row;
          ev_col[s]   = it.key_col;
          ev_press[s] = it.pressed;
          ev_count = ev_count + 1'b1;
          res.ok = 1'b1;
        end else begin
          n_dropped++;
        end
        awaited.push_back(res);
      end
      CMD_CANCEL: begin
        res.kind = KIND_CANCEL_ACK;
        // oldest position match wins, even if already cancelled
        for (i = 0; i < ev_count && !done; i++) begin
          s = ev_head + i[3:0];
          if (ev_row[s] == it.key_row && ev_col[s] == it.key_col) begin
            ev_dead[s] = 1'b1;
            done = 1'b1;
          end
        end
        res.ok = done;
        if (done) n_cancel_hit++;
        else n_cancel_miss++;
        awaited.push_back(res);
      end
      CMD_TICK: begin
        now_ticks = now_ticks + 1;
        while (ev_count != 0 && n < MAX_OUT && !done) begin
          s = ev_head;
          if (!ev_dead[s]) begin
            lag = now_ticks - ev_fire[s];
            if (lag[31]) begin
              done = 1'b1;   // head is live but not yet due
            end else begin
              if (n != 0) awaited.push_back(held);
              held = '0;
              held.kind        = KIND_FIRED;
              held.out_keycode = ev_key[s];
              held.out_row     = ev_row[s];
              held.out_col     = ev_col[s];
              held.out_pressed = ev_press[s];
              n++;
            end
          end
          if (!done) begin
            ev_head = ev_head + 1'b1;
            ev_count = ev_count - 1'b1;
          end
        end
        if (n == 0) begin
          res.kind = KIND_NONE_DUE;
          awaited.push_back(res);
          n_idle_ticks++;
        end else begin
          held.last = 1'b1;
          awaited.push_back(held);
          n_fired += n;
          if (n > longest_burst) longest_burst = n;
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_event_queue(in_data);
        n_accepted++;
      end
      if (in_valid && in_stall) begin
        // item stays on the bus
      end else if (cmd_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_data <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= STALL_STRETCH;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        n_errs++;
        $display("%0t: unexpected result, expected none, actual %s", $time, show(out_data));
      end else begin
        want = awaited.pop_front();
        if (out_data !== want) begin
          n_errs++;
          $display("%0t: mismatch, expected %s, actual %s", $time, show(want),
                   show(out_data));
        end
      end
    end
  end

  // watchdog on cycles with no transfer on any port
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results still awaited", $time, awaited.size());
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_item(input in_item_t it);
    cmd_q.push_back(it);
    n_queued++;
  endtask

  task automatic pick_pos(output logic [7:0] row, output logic [7:0] col);
    int k;
    if ($urandom_range(0, 3) == 0) begin
      row = 8'($urandom);
      col = 8'($urandom);
    end else begin
      k = $urandom_range(0, 5);
      row = pool_row[k];
      col = pool_col[k];
    end
  endtask

  // press, some ticks, maybe a cancel (tap released early), then release
  task automatic push_key_sequence(input int span);
    logic [7:0] row;
    logic [7:0] col;
    int         n;
    pick_pos(row, col);
    push_item(key_cmd(CMD_ENQ, 16'($urandom), row, col, 1'b1));
    n = $urandom_range(0, span);
    repeat (n) push_item(key_cmd(CMD_TICK, 16'($urandom), 8'($urandom), 8'($urandom),
                                 1'($urandom)));
    if ($urandom_range(0, 1) == 1)
      push_item(key_cmd(CMD_CANCEL, 16'($urandom), row, col, 1'($urandom)));
    push_item(key_cmd(CMD_ENQ, 16'($urandom), row, col, 1'b0));
  endtask

  task automatic run_random(input int count, input int span);
    logic [7:0] row;
    logic [7:0] col;
    int         stop_at;
    int         k;
    for (k = 0; k < 6; k++) begin
      pool_row[k] = 8'($urandom);
      pool_col[k] = 8'($urandom);
    end
    stop_at = n_queued + count;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        pick_pos(row, col);
        push_item(key_cmd(2'($urandom_range(0, 3)), 16'($urandom), row, col,
                          1'($urandom)));
      end else begin
        push_key_sequence(span);
      end
    end
  endtask

  task automatic wait_quiet;
    do @(negedge clk); while (cmd_q.size() != 0 || in_valid || awaited.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_check(input logic [15:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= TAP_TERM_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== want) begin
      n_errs++;
      $display("%0t: tap term readback, expected %h, actual %h", $time, want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TAP_TERM_ADDR;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tap_term = value;
    n_tap_settings++;
    cfg_check(value);
    @(negedge clk);
  endtask

  initial begin
    int         i;
    logic [15:0] t;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    cfg_check(TAP_TERM_RESET);
    @(negedge clk);

    // unknown command, extremes, double cancel, cancel miss
    push_item(key_cmd(2'd3, 16'hffff, 8'hff, 8'hff, 1'b1));
    push_item(key_cmd(CMD_ENQ, 16'hffff, 8'hff, 8'hff, 1'b1));
    push_item(key_cmd(CMD_ENQ, 16'h0000, 8'h00, 8'h00, 1'b0));
    push_item(key_cmd(CMD_ENQ, 16'ha5c3, 8'hff, 8'hff, 1'b0));
    push_item(key_cmd(CMD_CANCEL, 16'h0000, 8'hff, 8'hff, 1'b0));
    push_item(key_cmd(CMD_CANCEL, 16'hffff, 8'hff, 8'hff, 1'b1));
    push_item(key_cmd(CMD_CANCEL, 16'h0000, 8'h12, 8'h34, 1'b0));
    push_item(key_cmd(CMD_CANCEL, 16'h0000, 8'h00, 8'h00, 1'b0));
    push_item(key_cmd(CMD_TICK, 16'h0000, 8'h00, 8'h00, 1'b0));
    push_item(key_cmd(CMD_CANCEL, 16'h0000, 8'hff, 8'hff, 1'b0));
    push_item(key_cmd(CMD_TICK, 16'hffff, 8'hff, 8'hff, 1'b1));
    wait_quiet();

    // zero tap term: fill the queue, overflow it, then fire all at once
    cfg_write(16'd0);
    for (i = 0; i < DEPTH; i++)
      push_item(key_cmd(CMD_ENQ, 16'($urandom), 8'(i), 8'(DEPTH - 1 - i), 1'(i)));
    push_item(key_cmd(CMD_ENQ, 16'hbeef, 8'h55, 8'haa, 1'b1));
    push_item(key_cmd(CMD_TICK, 16'h0000, 8'h00, 8'h00, 1'b0));
    wait_quiet();

    cfg_write(16'd1);
    run_random(110, 3);
    wait_quiet();

    t = 16'($urandom_range(2, 6));
    cfg_write(t);
    run_random(55, t + 2);
    wait_quiet();
    steady = 1'b1;
    run_random(55, t + 2);
    wait_quiet();
    steady = 1'b0;

    // long receiver hold-off while commands keep coming
    t = 16'($urandom_range(7, 16));
    cfg_write(t);
    run_random(110, t + 2);
    repeat (20) @(negedge clk);
    hold_req++;
    wait_quiet();

    // longest tap term: new entries do not come due, queue fills and drops
    cfg_write(16'hffff);
    run_random(80, 4);
    wait_quiet();

    $display("Ran %0d commands over %0d tap-term settings: %0d events fired, longest burst %0d,",
             n_accepted, n_tap_settings, n_fired, longest_burst);
    $display("%0d idle ticks, %0d full-queue drops, %0d cancels matched, %0d missed.",
             n_idle_ticks, n_dropped, n_cancel_hit, n_cancel_miss);
    if (n_errs == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
